// ===== sv/lbc_pkg.sv =====
// lbc_pkg: shared types and codes of the LRU block cache.
// Used by lbc_cell, lru_block_cache and lbc_checker; no dependencies.
`default_nettype none
package lbc_pkg;
  localparam int TAG_W = 12;
  localparam int IDX_W = 12;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_REJ  = 2'd2;

  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_ENTRIES = 2'd1;

  typedef struct packed {
    logic             vld;
    logic [TAG_W-1:0] tag;
    logic             found;
    logic [IDX_W-1:0] fidx;
    logic [31:0]      btime;
    logic [IDX_W-1:0] bidx;
  } scan_t;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             set_tag;
    logic [TAG_W-1:0] tag;
    logic [31:0]      stamp;
  } cwr_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_STREAM = 3'b100
  } state_t;
endpackage
`default_nettype wire

// ===== sv/lbc_cell.sv =====
// lbc_cell: one cache entry (valid, tag, timestamp) and one stage of the search chain.
// Depends on lbc_pkg.
`default_nettype none
module lbc_cell import lbc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [IDX_W:0] live,
  input  cwr_t           cw,
  input  scan_t          si,
  output scan_t          so
);
  logic             valid_r;
  logic [TAG_W-1:0] tag_r;
  logic [31:0]      time_r;
  scan_t            so_r, so_nxt;
  logic             act;

  assign act = ((IDX_W+1)'(IDX) < live);
  assign so  = so_r;

  always_comb begin
    so_nxt = si;
    if (si.vld && act) begin
      if (!si.found && valid_r && (tag_r == si.tag)) begin
        so_nxt.found = 1'b1;
        so_nxt.fidx  = IDX_W'(IDX);
      end
      if (time_r < si.btime) begin
        so_nxt.btime = time_r;
        so_nxt.bidx  = IDX_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r    <= '0;
      valid_r <= 1'b0;
      time_r  <= '0;
    end else begin
      so_r <= so_nxt;
      if (cw.clr) begin
        valid_r <= 1'b0;
        time_r  <= '0;
      end else if (cw.en && (cw.idx == IDX_W'(IDX))) begin
        time_r <= cw.stamp;
        if (cw.set_tag) begin
          valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cw.clr && cw.en && cw.set_tag && (cw.idx == IDX_W'(IDX))) begin
      tag_r <= cw.tag;
    end
  end
endmodule
`default_nettype wire

// ===== sv/lru_block_cache.sv =====
// lru_block_cache: fully associative LRU block cache, top level.
// Depends on lbc_pkg and lbc_cell; holds the block data memory.
//
//  channel  ports                                   handshake
//  input    in_op in_disk in_block in_word_index    start & !busy
//           in_data_word
//  result   out_status out_read_word out_read_index out_strobe, one cycle
//           out_final_res out_query_count out_hit_count
//  config   cfg_index cfg_data                      cfg_valid & cfg_ready
//
// Lookups and word-0 writes search the chain of ENTRIES cells when enabled,
// one cell per cycle, then give one result, except that a lookup hit instead streams
// BLOCK_WORDS results from the data memory, one per cycle.
// Other items give their one result in the cycle after acceptance.
// Reset clears all entries at once; no clearing pass. Results cannot be stalled.
`default_nettype none
module lru_block_cache import lbc_pkg::*; #(
  parameter int ENTRIES     = 256,
  parameter int BLOCK_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_disk,
  input  logic [7:0]  in_block,
  input  logic [4:0]  in_word_index,
  input  logic [63:0] in_data_word,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_word,
  output logic [4:0]  out_read_index,
  output logic        out_final_res,
  output logic [31:0] out_query_count,
  output logic [31:0] out_hit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = $clog2(BLOCK_WORDS) + 1;
  localparam int DEPTH = ENTRIES * BLOCK_WORDS;
  localparam int AW = $clog2(DEPTH);

  state_t           state_r, state_nxt;
  logic             en_r, en_nxt;
  logic [8:0]       eiu_r, eiu_nxt;
  logic [31:0]      clk_r, clk_nxt, qcnt_r, qcnt_nxt, hcnt_r, hcnt_nxt;
  logic             pend_on_r, pend_on_nxt;
  logic [IW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [63:0]      data_r, data_nxt;
  logic             ostb_r, ostb_nxt;
  logic [1:0]       ost_r, ost_nxt;
  logic [4:0]       oidx_r, oidx_nxt;
  logic             ofin_r, ofin_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [IW-1:0]    slot_r, slot_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [KW-1:0]    rd_k_r, rd_k_nxt;
  logic             rd_last_r, rd_last_nxt;

  logic [63:0]      mem [DEPTH];
  logic [63:0]      mem_q_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [63:0]      mem_wd;

  scan_t            chain [ENTRIES+1];
  scan_t            chain_head;
  cwr_t             cw;
  logic [IDX_W:0]   live;
  logic             accept;
  logic [6:0]       wi7;
  logic             wlast, last0;
  logic [31:0]      tnew;
  logic [IW-1:0]    fidx, bidx;

  always_comb begin
    live = (IDX_W+1)'(eiu_r);
    if (live < (IDX_W+1)'(2)) begin
      live = (IDX_W+1)'(2);
    end else if (live > (IDX_W+1)'(ENTRIES)) begin
      live = (IDX_W+1)'(ENTRIES);
    end
  end

  assign chain[0] = chain_head;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      lbc_cell #(.IDX(gi)) u_cell (
        .clk(clk), .rst_n(rst_n), .live(live), .cw(cw),
        .si(chain[gi]), .so(chain[gi+1])
      );
    end
  endgenerate

  assign busy      = (state_r != S_IDLE) || rd_pend_r;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign wi7       = {2'b00, in_word_index};
  assign wlast     = (wi7 == 7'(BLOCK_WORDS - 1));
  assign last0     = (BLOCK_WORDS == 1);
  assign tnew      = (clk_r == SAT32) ? clk_r : clk_r + 32'd1;
  assign fidx      = chain[ENTRIES].fidx[IW-1:0];
  assign bidx      = chain[ENTRIES].bidx[IW-1:0];

  always_comb begin
    state_nxt = state_r; en_nxt = en_r; eiu_nxt = eiu_r; clk_nxt = clk_r;
    qcnt_nxt = qcnt_r; hcnt_nxt = hcnt_r; pend_on_nxt = pend_on_r;
    pend_idx_nxt = pend_idx_r; op_nxt = op_r; tag_nxt = tag_r; data_nxt = data_r;
    ostb_nxt = 1'b0; ost_nxt = ost_r; oidx_nxt = oidx_r; ofin_nxt = ofin_r;
    k_nxt = k_r; slot_nxt = slot_r;
    rd_pend_nxt = 1'b0; rd_k_nxt = rd_k_r; rd_last_nxt = rd_last_r;
    mem_we = 1'b0; mem_wa = '0; mem_wd = data_r; mem_re = 1'b0; mem_ra = '0;
    cw = '0;
    chain_head = '0;
    chain_head.btime = SAT32;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_op;
          tag_nxt  = {in_disk, in_block};
          data_nxt = in_data_word;
          ostb_nxt = 1'b1; ofin_nxt = 1'b1; oidx_nxt = in_word_index; ost_nxt = ST_REJ;
          if (in_op == OP_LOOKUP) begin
            oidx_nxt = '0;
            qcnt_nxt = (qcnt_r == SAT32) ? qcnt_r : qcnt_r + 32'd1;
            if (en_r) begin
              ostb_nxt = 1'b0;
              chain_head.vld = 1'b1;
              chain_head.tag = {in_disk, in_block};
              state_nxt = S_SCAN;
            end
          end else if (in_op == OP_BAD) begin
            oidx_nxt = '0;
          end else if (!en_r || (wi7 >= 7'(BLOCK_WORDS))) begin
            ost_nxt = ST_REJ;
          end else if (in_word_index == 5'd0) begin
            ostb_nxt = 1'b0;
            pend_on_nxt = 1'b0;
            chain_head.vld = 1'b1;
            chain_head.tag = {in_disk, in_block};
            state_nxt = S_SCAN;
          end else if (pend_on_r) begin
            mem_we = 1'b1;
            mem_wa = AW'(pend_idx_r) * AW'(BLOCK_WORDS) + AW'(in_word_index);
            mem_wd = in_data_word;
            ost_nxt = ST_HIT; ofin_nxt = wlast;
            if (wlast) begin
              pend_on_nxt = 1'b0;
            end
          end else begin
            ost_nxt = ST_MISS;
          end
        end
      end
      S_SCAN: begin
        if (chain[ENTRIES].vld) begin
          state_nxt = S_IDLE;
          ostb_nxt = 1'b1; oidx_nxt = '0; ofin_nxt = 1'b1; ost_nxt = ST_MISS;
          priority if (op_r == OP_LOOKUP) begin
            if (chain[ENTRIES].found) begin
              ostb_nxt = 1'b0;
              clk_nxt = tnew;
              cw.en = 1'b1; cw.idx = IDX_W'(fidx); cw.stamp = tnew;
              hcnt_nxt = (hcnt_r == SAT32) ? hcnt_r : hcnt_r + 32'd1;
              slot_nxt = fidx; k_nxt = '0;
              state_nxt = S_STREAM;
            end
          end else if (op_r == OP_UPDATE) begin
            if (chain[ENTRIES].found) begin
              clk_nxt = tnew;
              cw.en = 1'b1; cw.idx = IDX_W'(fidx); cw.stamp = tnew;
              mem_we = 1'b1; mem_wa = AW'(fidx) * AW'(BLOCK_WORDS);
              pend_on_nxt = !last0; pend_idx_nxt = fidx;
              ost_nxt = ST_HIT; ofin_nxt = last0;
            end
          end else begin
            if (chain[ENTRIES].found) begin
              ost_nxt = ST_REJ;
            end else begin
              clk_nxt = tnew;
              cw.en = 1'b1; cw.idx = IDX_W'(bidx); cw.stamp = tnew;
              cw.set_tag = 1'b1; cw.tag = tag_r;
              mem_we = 1'b1; mem_wa = AW'(bidx) * AW'(BLOCK_WORDS);
              pend_on_nxt = !last0; pend_idx_nxt = bidx;
              ost_nxt = ST_HIT; ofin_nxt = last0;
            end
          end
        end
      end
      S_STREAM: begin
        mem_re = 1'b1;
        mem_ra = AW'(slot_r) * AW'(BLOCK_WORDS) + AW'(k_r);
        rd_pend_nxt = 1'b1;
        rd_k_nxt = k_r;
        rd_last_nxt = (k_r == KW'(BLOCK_WORDS - 1));
        if (k_r == KW'(BLOCK_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      if (cfg_index == CFG_ENABLE) begin
        en_nxt = cfg_data[0];
        cw.clr = 1'b1;
        clk_nxt = '0;
        pend_on_nxt = 1'b0;
        pend_idx_nxt = '0;
      end else if (cfg_index == CFG_ENTRIES) begin
        eiu_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; en_r <= 1'b0; eiu_r <= 9'd256; clk_r <= '0;
      qcnt_r <= '0; hcnt_r <= '0; pend_on_r <= 1'b0; pend_idx_r <= '0;
      ostb_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; en_r <= en_nxt; eiu_r <= eiu_nxt; clk_r <= clk_nxt;
      qcnt_r <= qcnt_nxt; hcnt_r <= hcnt_nxt; pend_on_r <= pend_on_nxt;
      pend_idx_r <= pend_idx_nxt; ostb_r <= ostb_nxt; rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; tag_r <= tag_nxt; data_r <= data_nxt;
    ost_r <= ost_nxt; oidx_r <= oidx_nxt; ofin_r <= ofin_nxt;
    k_r <= k_nxt; slot_r <= slot_nxt; rd_k_r <= rd_k_nxt; rd_last_r <= rd_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_ra];
    end
  end

  assign out_strobe      = ostb_r | rd_pend_r;
  assign out_status      = rd_pend_r ? ST_HIT : ost_r;
  assign out_read_word   = rd_pend_r ? mem_q_r : 64'd0;
  assign out_read_index  = rd_pend_r ? 5'(rd_k_r) : oidx_r;
  assign out_final_res   = rd_pend_r ? rd_last_r : ofin_r;
  assign out_query_count = qcnt_r;
  assign out_hit_count   = hcnt_r;
endmodule
`default_nettype wire

// ===== sv/lbc_checker.sv =====
// lbc_checker: port-level assertions for lru_block_cache, bound to the top level.
// Depends on lbc_pkg.
`default_nettype none
module lbc_port_checker import lbc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [63:0] out_read_word,
  input logic        out_final_res,
  input logic [31:0] out_query_count,
  input logic [31:0] out_hit_count
);
  a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_final_res && busy |=> out_strobe)
    else $error("block stream broke off");

  a_fail_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_HIT) |-> out_final_res)
    else $error("failed item not final");

  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_HIT) |-> (out_read_word == 64'd0))
    else $error("nonzero word on failed item");

  a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_hit_count >= $past(out_hit_count)))
    else $error("hit count went down");

  a_query_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_query_count >= $past(out_query_count)))
    else $error("query count went down");
endmodule

bind lru_block_cache lbc_port_checker u_lbc_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_strobe(out_strobe), .out_status(out_status), .out_read_word(out_read_word),
  .out_final_res(out_final_res), .out_query_count(out_query_count),
  .out_hit_count(out_hit_count)
);
`default_nettype wire

// ===== sim/lbc_checker.sv =====
// lbc_checker: watches the item, result and register channels of lru_block_cache,
// predicts every result from its own copy of the cache and compares in order.
// Depends on lbc_pkg.
module lbc_checker import lbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_disk,
  input  logic [7:0]  in_block,
  input  logic [4:0]  in_word_index,
  input  logic [63:0] in_data_word,
  input  logic        out_strobe,
  input  logic [1:0]  out_status,
  input  logic [63:0] out_read_word,
  input  logic [4:0]  out_read_index,
  input  logic        out_final_res,
  input  logic [31:0] out_query_count,
  input  logic [31:0] out_hit_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          fail_count,
  output logic        results_drained
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 256;
  localparam int NWORD = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] word;
    logic [4:0]  index;
    logic        fin;
    logic [31:0] queries;
    logic [31:0] hits;
  } cache_result_t;

  cache_result_t expected_results[$];

  logic              slot_valid [NSLOT];
  logic [TAG_W-1:0]  slot_tag   [NSLOT];
  logic [31:0]       slot_time  [NSLOT];
  logic [63:0]       slot_data  [NSLOT][NWORD];
  logic [NWORD-1:0]  slot_filled[NSLOT];
  logic [31:0]       use_clock, queries, hits;
  logic              write_open;
  int                write_slot;
  logic              enabled;
  logic [8:0]        slots_cfg;

  assign results_drained = (expected_results.size() == 0);

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

  function automatic int live_slots();
    int n;
    n = slots_cfg;
    if (n < 2) n = 2;
    if (n > NSLOT) n = NSLOT;
    return n;
  endfunction

  function automatic int find_slot(logic [TAG_W-1:0] t);
    for (int i = 0; i < live_slots(); i++)
      if (slot_valid[i] && slot_tag[i] == t) return i;
    return -1;
  endfunction

  // a lookup of this tag reads only words written since reset
  function automatic bit tag_readable(logic [TAG_W-1:0] t);
    int s;
    s = find_slot(t);
    if (!enabled || s < 0) return 1;
    return &slot_filled[s];
  endfunction

  function automatic void clear_entries();
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0;
      slot_tag[i] = '0;
      slot_time[i] = '0;
    end
    use_clock = '0;
    write_open = 1'b0;
    write_slot = 0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [63:0] w, logic [4:0] idx,
                                      logic fin);
    cache_result_t r;
    r.status = st;
    r.word = w;
    r.index = idx;
    r.fin = fin;
    r.queries = queries;
    r.hits = hits;
    expected_results.push_back(r);
  endfunction

  function automatic void stamp_slot(int s);
    use_clock = sat_inc(use_clock);
    slot_time[s] = use_clock;
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [TAG_W-1:0] t, logic [4:0] wi,
                                       logic [63:0] dw);
    int s;
    int best;
    s = -1;
    best = 0;
    if (op == OP_LOOKUP) begin
      queries = sat_inc(queries);
      if (!enabled) begin
        push_result(ST_REJ, '0, '0, 1'b1);
        return;
      end
      s = find_slot(t);
      if (s < 0) begin
        push_result(ST_MISS, '0, '0, 1'b1);
        return;
      end
      stamp_slot(s);
      hits = sat_inc(hits);
      for (int k = 0; k < NWORD; k++)
        push_result(ST_HIT, slot_data[s][k], 5'(k), k == NWORD - 1);
    end else if (op == OP_BAD) begin
      push_result(ST_REJ, '0, '0, 1'b1);
    end else if (!enabled) begin
      push_result(ST_REJ, '0, wi, 1'b1);
    end else if (wi == 0) begin
      write_open = 1'b0;
      if (op == OP_UPDATE) begin
        s = find_slot(t);
        if (s < 0) begin
          push_result(ST_MISS, '0, '0, 1'b1);
          return;
        end
      end else begin
        if (find_slot(t) >= 0) begin
          push_result(ST_REJ, '0, '0, 1'b1);
          return;
        end
        for (int i = 1; i < live_slots(); i++)
          if (slot_time[i] < slot_time[best]) best = i;
        s = best;
        slot_tag[s] = t;
        slot_valid[s] = 1'b1;
      end
      stamp_slot(s);
      slot_data[s][0] = dw;
      slot_filled[s][0] = 1'b1;
      write_open = 1'b1;
      write_slot = s;
      push_result(ST_HIT, '0, '0, 1'b0);
    end else if (!write_open) begin
      push_result(ST_MISS, '0, wi, 1'b1);
    end else begin
      slot_data[write_slot][wi] = dw;
      slot_filled[write_slot][wi] = 1'b1;
      if (wi == NWORD - 1) write_open = 1'b0;
      push_result(ST_HIT, '0, wi, wi == NWORD - 1);
    end
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    cache_result_t got;
    if (!rst_n) begin
      clear_entries();
      for (int i = 0; i < NSLOT; i++) slot_filled[i] = '0;
      queries = '0;
      hits = '0;
      enabled = 1'b0;
      slots_cfg = 9'd256;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_strobe) begin
        got = '{out_status, out_read_word, out_read_index, out_final_res,
                out_query_count, out_hit_count};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status %0d word %h index %0d", got.status,
                     got.word, got.index);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st %0d w %h i %0d f %0d q %0d h %0d / got st %0d w %h i %0d f %0d q %0d h %0d",
                       want.status, want.word, want.index, want.fin, want.queries,
                       want.hits, got.status, got.word, got.index, got.fin,
                       got.queries, got.hits);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ENABLE) begin
          enabled = cfg_data[0];
          clear_entries();
        end else if (cfg_index == CFG_ENTRIES) begin
          slots_cfg = cfg_data;
        end
      end
      if (start && !busy)
        predict_item(in_op, {in_disk, in_block}, in_word_index, in_data_word);
    end
  end
endmodule

// ===== sim/testbench.sv =====
// testbench: drives lru_block_cache with directed and random commands and
// register writes, and gives the verdict from lbc_checker's failure count.
// Depends on lbc_pkg, lru_block_cache and lbc_checker.
module testbench;
  import lbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = '0;
  logic [3:0]  in_disk = '0;
  logic [7:0]  in_block = '0;
  logic [4:0]  in_word_index = '0;
  logic [63:0] in_data_word = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [63:0] out_read_word;
  logic [4:0]  out_read_index;
  logic        out_final_res;
  logic [31:0] out_query_count, out_hit_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  int          fail_count;
  logic        results_drained;
  int          cycles = 0;
  int          items_sent = 0;
  int          sender_idle_pct = 0;
  logic [11:0] tag_pool [8];

  always #5 clk = ~clk;

  lru_block_cache dut (.*);
  lbc_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [11:0] t, logic [4:0] wi, logic [63:0] dw);
    int n;
    n = 0;
    while ($urandom_range(99) < sender_idle_pct && n < 8) n++;
    if (n > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_op = op;
    {in_disk, in_block} = t;
    in_word_index = wi;
    in_data_word = dw;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk) start = 1'b0;
    while (!results_drained || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic write_block(logic [1:0] op, logic [11:0] t, int nwords);
    for (int k = 0; k < nwords; k++) send_item(op, t, 5'(k), {$urandom, $urandom});
  endtask

  task automatic lookup(logic [11:0] t);
    @(negedge clk) start = 1'b0;
    if (chk.tag_readable(t)) send_item(OP_LOOKUP, t, 5'($urandom), {$urandom, $urandom});
  endtask

  function automatic logic [11:0] pick_tag();
    if ($urandom_range(9) == 0) return 12'($urandom);
    return tag_pool[$urandom_range(7)];
  endfunction

  initial begin
    int goal;
    int pick;
    for (int i = 0; i < 8; i++) tag_pool[i] = 12'($urandom);
    tag_pool[0] = 12'h000;
    tag_pool[1] = 12'hFFF;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // disabled cache, then directed items on the enabled cache
    send_item(OP_LOOKUP, 12'hFFF, 5'd31, '1);
    send_item(OP_UPDATE, 12'h000, 5'd0, '1);
    send_item(OP_INSERT, 12'hFFF, 5'd31, '0);
    send_item(OP_BAD, 12'h5A5, 5'd7, '1);
    write_reg(CFG_ENABLE, 9'd1);
    send_item(OP_UPDATE, 12'h123, 5'd0, '0);
    send_item(OP_INSERT, 12'h321, 5'd31, '1);
    send_item(OP_BAD, 12'hFFF, 5'd0, '0);
    lookup(12'h000);
    write_block(OP_INSERT, 12'hFFF, 3);
    send_item(OP_INSERT, 12'hFFF, 5'd0, '1);
    write_block(OP_INSERT, 12'h000, 1);
    lookup(12'hABC);
    write_block(OP_UPDATE, 12'hFFF, 2);
    lookup(12'hFFF);

    goal = items_sent + 330;
    for (int phase = 0; items_sent < goal; phase++) begin
      case (phase % 6)
        0: write_reg(CFG_ENTRIES, 9'd256);
        1: write_reg(CFG_ENTRIES, 9'd2);
        2: write_reg(CFG_ENTRIES, 9'($urandom));
        3: write_reg(CFG_ENTRIES, 9'd0);
        4: write_reg(CFG_ENTRIES, 9'd511);
        default: write_reg(CFG_ENTRIES, 9'($urandom_range(2, 6)));
      endcase
      if (phase % 5 == 4) write_reg(CFG_ENABLE, 9'($urandom_range(1)));
      else if (phase % 5 == 0) write_reg(CFG_ENABLE, 9'd1);
      case (phase % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 75;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 23;
      endcase
      for (int s = 0; s < 6 && items_sent < goal; s++) begin
        pick = $urandom_range(99);
        if (pick < 30) write_block(OP_INSERT, pick_tag(), 32);
        else if (pick < 45) write_block(OP_UPDATE, pick_tag(), 32);
        else if (pick < 75) lookup(pick_tag());
        else if (pick < 85) write_block(2'($urandom_range(1, 2)), pick_tag(),
                                        $urandom_range(1, 31));
        else if (pick < 95)
          send_item(2'($urandom), 12'($urandom), 5'($urandom), {$urandom, $urandom});
        else drain();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
